FILE: hdl/eiaj_pcm_line_block_encoder_top_defines.svh
// Assertion macros used by the checker file.
`ifndef EIAJ_PCM_LINE_BLOCK_ENCODER_TOP_DEFINES_SVH
`define EIAJ_PCM_LINE_BLOCK_ENCODER_TOP_DEFINES_SVH
// Implication under clock and reset.
`define EPLB_ASSERT_IMP(lbl, clk, rstn, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
        else $error("assertion failed");
// Next-cycle implication under clock and reset.
`define EPLB_ASSERT_NXT(lbl, clk, rstn, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
        else $error("assertion failed");
`endif

FILE: hdl/eplb_pkg.sv
// ----------------------------------------------------------------------------
// eplb_pkg
// Constants, types and helper functions of the PCM line block encoder.
// ----------------------------------------------------------------------------
package eplb_pkg;
    localparam int RingDepth = 113;
    localparam int SlotW     = $clog2(RingDepth);
    localparam int AddrW     = SlotW + 2;
    localparam int MemDepth  = RingDepth * 4;

    localparam logic [0:0] CfgSixteen  = 1'b0;
    localparam logic [0:0] CfgEmphasis = 1'b1;

    localparam logic [15:0] CrcPoly  = 16'h1021;
    localparam logic [15:0] CrcInit  = 16'hFFFF;
    localparam logic [13:0] LfsrTap  = 14'h0101;
    localparam logic [13:0] SyncA    = 14'h3333;
    localparam logic [13:0] SyncB    = 14'h0CCC;

    localparam logic signed [17:0] CoefX  = 18'sd38156;
    localparam logic signed [17:0] CoefX1 = -18'sd24051;
    localparam logic signed [17:0] CoefY1 = 18'sd2278;

    typedef logic [SlotW-1:0] slot_t;
    typedef logic [AddrW-1:0] addr_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic        load;      // capture input line
        logic        emph_en;   // run filter on sample emph_idx
        logic [2:0]  emph_idx;
        logic        wr_en;     // write one sample to ring
        logic [2:0]  wr_idx;
        logic        rd_en;     // issue ring read
        logic        rd_right;
        addr_t       rd_addr;
        logic        cap_en;    // capture previous read data
        logic [4:0]  cap_sel;
        logic        crc_start;
        logic        crc_step;
        logic [2:0]  crc_word;
        logic        out_load;
    } cmd_t;

    function automatic logic [13:0] top14(input logic [15:0] u);
        return u[15:2];
    endfunction

    function automatic logic [13:0] lfsr_step(input logic [13:0] w);
        logic [13:0] v;
        v = {w[12:0], 1'b0};
        if (w[13]) v = v ^ LfsrTap;
        return v;
    endfunction

    // Slot d blocks before k, modulo the ring depth.
    function automatic slot_t back(input slot_t k, input slot_t d);
        logic [SlotW:0] s;
        s = {1'b0, k} + (SlotW+1)'(RingDepth) - {1'b0, d};
        if (s >= (SlotW+1)'(RingDepth)) s = s - (SlotW+1)'(RingDepth);
        return s[SlotW-1:0];
    endfunction
endpackage

FILE: hdl/eiaj_pcm_line_block_encoder_top.sv
// ----------------------------------------------------------------------------
// eiaj_pcm_line_block_encoder_top
// PCM audio line block encoder: one video line in, eight words and CRC out.
// ----------------------------------------------------------------------------
// Input channel s_*: one transaction per video line. s_command = 0 carries
// three stereo samples, s_command = 1 requests a control line.
// Output channel m_*: one transaction per input, eight 14-bit words and the
// CRC over them.
// Configuration channel cfg_*: index 0 selects 16-bit mode, index 1 turns on
// pre-emphasis. Writes are taken only while the block is idle and no line
// is being offered.
// A data line goes through input load, filter (if on), ring writes, ring
// reads, CRC steps and output load; a control line goes from load straight
// to the CRC steps. One ring read port; the CRC takes one word per cycle.
// Only one line is in flight; s_ready is high while the block is idle.
// Reset clears the ring history flags, filter state and slot pointer, so no
// clearing pass is needed. If the receiver stalls, the result waits in the
// output register; a following line waits at its output load until taken.
module eiaj_pcm_line_block_encoder_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_command,
    input  logic [15:0] s_left_0,
    input  logic [15:0] s_right_0,
    input  logic [15:0] s_left_1,
    input  logic [15:0] s_right_1,
    input  logic [15:0] s_left_2,
    input  logic [15:0] s_right_2,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [13:0] m_word_0,
    output logic [13:0] m_word_1,
    output logic [13:0] m_word_2,
    output logic [13:0] m_word_3,
    output logic [13:0] m_word_4,
    output logic [13:0] m_word_5,
    output logic [13:0] m_word_6,
    output logic [13:0] m_word_7,
    output logic [15:0] m_crc_word,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [0:0]  cfg_data
);
    logic sixteen_reg, emph_reg, out_free;
    eplb_pkg::cmd_t  cmd;
    eplb_pkg::slot_t slot;

    assign cfg_ready = s_ready && !s_valid;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sixteen_reg <= 1'b0;
            emph_reg    <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                eplb_pkg::CfgSixteen:  sixteen_reg <= cfg_data[0];
                eplb_pkg::CfgEmphasis: emph_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    eplb_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .s_command,
        .emphasis_on(emph_reg), .out_free, .cmd, .slot
    );

    eplb_datapath u_dp (
        .aclk, .aresetn, .cmd, .slot,
        .sixteen_bit_mode(sixteen_reg), .emphasis_on(emph_reg), .s_command,
        .s_left_0, .s_right_0, .s_left_1, .s_right_1, .s_left_2, .s_right_2,
        .out_free, .m_ready, .m_valid,
        .m_word_0, .m_word_1, .m_word_2, .m_word_3,
        .m_word_4, .m_word_5, .m_word_6, .m_word_7, .m_crc_word
    );
endmodule

FILE: hdl/eplb_ctrl.sv
// ----------------------------------------------------------------------------
// eplb_ctrl
// Sequencer: filter, ring write, ring reads, CRC and output hand-off.
// ----------------------------------------------------------------------------
module eplb_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_command,
    input  logic              emphasis_on,
    input  logic              out_free,
    output eplb_pkg::cmd_t    cmd,
    output eplb_pkg::slot_t   slot
);
    typedef enum logic [2:0] {
        ST_IDLE, ST_EMPH, ST_WRITE, ST_READ, ST_CRC, ST_OUT
    } state_t;

    state_t              state_reg, state_next;
    logic [4:0]          cnt_reg, cnt_next;
    eplb_pkg::slot_t     slot_reg, slot_next;
    eplb_pkg::slot_t     rs;

    assign slot    = slot_reg;
    assign s_ready = (state_reg == ST_IDLE);

    // Read plan: 0..5 interleave words, 6..11 block k-96, 12..17 block k-112.
    always_comb begin
        logic [1:0] col;
        logic       rgt;
        eplb_pkg::slot_t d;
        state_next = state_reg;
        cnt_next   = cnt_reg;
        slot_next  = slot_reg;
        cmd        = '0;
        col = 2'd0; rgt = 1'b0; d = '0; rs = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load = 1'b1;
                    cnt_next = '0;
                    if (s_command) state_next = ST_CRC;
                    else if (emphasis_on) state_next = ST_EMPH;
                    else state_next = ST_WRITE;
                    cmd.crc_start = s_command;
                end
            end
            ST_EMPH: begin
                cmd.emph_en  = 1'b1;
                cmd.emph_idx = cnt_reg[2:0];
                if (cnt_reg == 5'd5) begin
                    cnt_next = '0; state_next = ST_WRITE;
                end else cnt_next = cnt_reg + 5'd1;
            end
            ST_WRITE: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_idx = cnt_reg[2:0];
                if (cnt_reg == 5'd5) begin
                    cnt_next = '0; state_next = ST_READ;
                end else cnt_next = cnt_reg + 5'd1;
            end
            ST_READ: begin
                if (cnt_reg < 5'd6) begin
                    rgt = cnt_reg[0];
                    col = cnt_reg[2:1];
                    d   = eplb_pkg::slot_t'(16 * cnt_reg);
                end else if (cnt_reg < 5'd12) begin
                    rgt = cnt_reg[0];
                    col = 2'((cnt_reg - 5'd6) >> 1);
                    d   = eplb_pkg::slot_t'(96);
                end else if (cnt_reg < 5'd18) begin
                    rgt = cnt_reg[0];
                    col = 2'((cnt_reg - 5'd12) >> 1);
                    d   = eplb_pkg::slot_t'(112);
                end
                rs = eplb_pkg::back(slot_reg, d);
                cmd.rd_en    = (cnt_reg < 5'd18);
                cmd.rd_right = rgt;
                cmd.rd_addr  = {rs, col};
                cmd.cap_en   = (cnt_reg != 5'd0);
                cmd.cap_sel  = cnt_reg - 5'd1;
                if (cnt_reg == 5'd18) begin
                    cmd.cap_en  = 1'b1;
                    cnt_next    = '0;
                    state_next  = ST_CRC;
                    cmd.crc_start = 1'b1;
                    slot_next = (slot_reg == eplb_pkg::slot_t'(eplb_pkg::RingDepth - 1))
                        ? '0 : slot_reg + 1'b1;
                end else cnt_next = cnt_reg + 5'd1;
            end
            ST_CRC: begin
                cmd.crc_step = 1'b1;
                cmd.crc_word = cnt_reg[2:0];
                if (cnt_reg == 5'd7) begin
                    cnt_next = '0; state_next = ST_OUT;
                end else cnt_next = cnt_reg + 5'd1;
            end
            ST_OUT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            slot_reg  <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            slot_reg  <= slot_next;
        end
    end
endmodule

FILE: hdl/eplb_datapath.sv
// ----------------------------------------------------------------------------
// eplb_datapath
// Filter, sample rings, parity and Q/S words, CRC and output register.
// ----------------------------------------------------------------------------
module eplb_datapath (
    input  logic              aclk,
    input  logic              aresetn,
    input  eplb_pkg::cmd_t    cmd,
    input  eplb_pkg::slot_t   slot,
    input  logic              sixteen_bit_mode,
    input  logic              emphasis_on,
    input  logic              s_command,
    input  logic [15:0]       s_left_0, s_right_0, s_left_1,
    input  logic [15:0]       s_right_1, s_left_2, s_right_2,
    output logic              out_free,
    input  logic              m_ready,
    output logic              m_valid,
    output logic [13:0]       m_word_0, m_word_1, m_word_2, m_word_3,
    output logic [13:0]       m_word_4, m_word_5, m_word_6, m_word_7,
    output logic [15:0]       m_crc_word
);
    // Sample order: L0 R0 L1 R1 L2 R2.
    logic [15:0] smp_reg [6];
    logic        ctl_reg;
    logic [15:0] lin_reg, lout_reg, rin_reg, rout_reg;
    logic [15:0] cap_reg [18];
    logic [13:0] w_reg [8];
    logic [15:0] crc_reg;
    logic        mvalid_reg;

    // Rings: four columns per slot, column 3 unused. Written-flags give the
    // cleared value for never-written slots.
    logic [15:0] lmem [eplb_pkg::MemDepth];
    logic [15:0] rmem [eplb_pkg::MemDepth];
    logic [eplb_pkg::RingDepth-1:0] vld_reg;
    logic [15:0] rd_data_reg;
    logic        rd_vld_reg;

    // Filter path.
    logic signed [15:0] fx, fx1, fy1;
    logic signed [35:0] acc;
    logic signed [21:0] fy;
    logic [15:0] fsat;
    logic        fr;
    assign fr  = cmd.emph_idx[0];
    assign fx  = smp_reg[cmd.emph_idx];
    assign fx1 = fr ? rin_reg : lin_reg;
    assign fy1 = fr ? rout_reg : lout_reg;
    assign acc = fx * eplb_pkg::CoefX + fx1 * eplb_pkg::CoefX1
               + fy1 * eplb_pkg::CoefY1;
    assign fy  = acc[35:14];
    always_comb begin
        if (fy > 22'sd32767) fsat = 16'h7FFF;
        else if (fy < -22'sd32768) fsat = 16'h8000;
        else fsat = fy[15:0];
    end

    logic [15:0] rd_val;
    assign rd_val = rd_vld_reg ? rd_data_reg : 16'h0000;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg  <= '0;
            lin_reg  <= '0; lout_reg <= '0; rin_reg <= '0; rout_reg <= '0;
        end else begin
            if (cmd.wr_en && cmd.wr_idx == 3'd5) vld_reg[slot] <= 1'b1;
            if (cmd.emph_en) begin
                if (fr) begin
                    rin_reg <= fx; rout_reg <= fsat;
                end else begin
                    lin_reg <= fx; lout_reg <= fsat;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            smp_reg[0] <= s_left_0;  smp_reg[1] <= s_right_0;
            smp_reg[2] <= s_left_1;  smp_reg[3] <= s_right_1;
            smp_reg[4] <= s_left_2;  smp_reg[5] <= s_right_2;
            ctl_reg    <= s_command;
        end
        if (cmd.emph_en) smp_reg[cmd.emph_idx] <= fsat;
        if (cmd.wr_en) begin
            if (cmd.wr_idx[0]) rmem[{slot, cmd.wr_idx[2:1]}] <= smp_reg[cmd.wr_idx];
            else lmem[{slot, cmd.wr_idx[2:1]}] <= smp_reg[cmd.wr_idx];
        end
        if (cmd.rd_en) begin
            rd_data_reg <= cmd.rd_right ? rmem[cmd.rd_addr] : lmem[cmd.rd_addr];
            rd_vld_reg  <= vld_reg[cmd.rd_addr[eplb_pkg::AddrW-1:2]];
        end
        if (cmd.cap_en) cap_reg[cmd.cap_sel] <= rd_val;
    end

    // Words assembled from captured samples.
    logic [13:0] wv [8];
    always_comb begin
        logic [15:0] p16, ps;
        logic [13:0] q;
        p16 = cap_reg[6] ^ cap_reg[7] ^ cap_reg[8] ^ cap_reg[9] ^ cap_reg[10] ^ cap_reg[11];
        ps  = cap_reg[12] ^ cap_reg[13] ^ cap_reg[14] ^ cap_reg[15] ^ cap_reg[16]
            ^ cap_reg[17];
        q = eplb_pkg::lfsr_step(eplb_pkg::top14(cap_reg[12]));
        q = eplb_pkg::lfsr_step(q ^ eplb_pkg::top14(cap_reg[13]));
        q = eplb_pkg::lfsr_step(q ^ eplb_pkg::top14(cap_reg[14]));
        q = eplb_pkg::lfsr_step(q ^ eplb_pkg::top14(cap_reg[15]));
        q = eplb_pkg::lfsr_step(q ^ eplb_pkg::top14(cap_reg[16]));
        q = eplb_pkg::lfsr_step(q ^ eplb_pkg::top14(cap_reg[17]));
        for (int i = 0; i < 6; i++) wv[i] = eplb_pkg::top14(cap_reg[i]);
        wv[6] = eplb_pkg::top14(p16);
        wv[7] = sixteen_bit_mode ?
            {cap_reg[12][1:0], cap_reg[13][1:0], cap_reg[14][1:0],
             cap_reg[15][1:0], cap_reg[16][1:0], cap_reg[17][1:0], ps[1:0]} : q;
        if (ctl_reg) begin
            wv[0] = eplb_pkg::SyncA; wv[1] = eplb_pkg::SyncB;
            wv[2] = eplb_pkg::SyncA; wv[3] = eplb_pkg::SyncB;
            wv[4] = '0; wv[5] = '0; wv[6] = '0;
            wv[7] = {12'd0, sixteen_bit_mode, !emphasis_on};
        end
    end

    // One 14-bit word of CRC per cycle.
    logic [15:0] crc_nx;
    always_comb begin
        logic [13:0] wd;
        logic        fb;
        wd = wv[cmd.crc_word];
        crc_nx = cmd.crc_start ? eplb_pkg::CrcInit : crc_reg;
        for (int b = 13; b >= 0; b--) begin
            fb = crc_nx[15] ^ wd[b];
            crc_nx = {crc_nx[14:0], 1'b0};
            if (fb) crc_nx = crc_nx ^ eplb_pkg::CrcPoly;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.crc_start) crc_reg <= eplb_pkg::CrcInit;
        if (cmd.crc_step) crc_reg <= crc_nx;
        if (cmd.out_load) begin
            for (int i = 0; i < 8; i++) w_reg[i] <= wv[i];
            m_crc_word <= crc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) mvalid_reg <= 1'b0;
        else if (cmd.out_load) mvalid_reg <= 1'b1;
        else if (m_ready) mvalid_reg <= 1'b0;
    end

    assign out_free = !mvalid_reg || m_ready;
    assign m_valid  = mvalid_reg;
    assign m_word_0 = w_reg[0]; assign m_word_1 = w_reg[1];
    assign m_word_2 = w_reg[2]; assign m_word_3 = w_reg[3];
    assign m_word_4 = w_reg[4]; assign m_word_5 = w_reg[5];
    assign m_word_6 = w_reg[6]; assign m_word_7 = w_reg[7];
endmodule

FILE: hdl/eplb_checker.sv
// ----------------------------------------------------------------------------
// eplb_checker
// Port-level checks of the encoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "eiaj_pcm_line_block_encoder_top_defines.svh"
module eplb_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [13:0] m_word_0
);
    // One line in flight: nothing is accepted right after an accept.
    `EPLB_ASSERT_NXT(a_one_line, aclk, aresetn, s_valid && s_ready, !s_ready)
    // No result newly appears in the cycle after a line is accepted.
    `EPLB_ASSERT_NXT(a_no_early, aclk, aresetn, s_valid && s_ready, !m_valid || $past(m_valid))
    // A stalled result holds.
    `EPLB_ASSERT_NXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_word_0))
endmodule

bind eiaj_pcm_line_block_encoder_top eplb_checker u_chk (
    .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready, .m_word_0
);

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for the PCM line block encoder: directed lines, then random lines.
// ----------------------------------------------------------------------------
// Every line that the encoder accepts is run through a behavioral encoder
// model kept in this file. The model's output is queued, and each result
// transaction is checked against it field by field. Both channels idle and
// stall at random. The configuration changes only between phases, once all
// results have drained.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic CmdData    = 1'b0;
    localparam logic CmdControl = 1'b1;
    localparam int   RingSize   = 113;
    localparam int   StallLen   = 400;
    localparam int   DogLimit   = 3000;
    localparam int   RandItems  = 100;
    localparam logic [13:0] SyncA = eplb_pkg::SyncA;
    localparam logic [13:0] SyncB = eplb_pkg::SyncB;

    typedef struct {
        logic [13:0] w [8];
        logic [15:0] crc;
    } line_words_t;

    typedef struct packed {
        logic             cmd;
        logic [0:5][15:0] smp;
        logic             chk;
        logic [0:7][13:0] w;
    } line_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_command;
    logic [15:0] s_left_0, s_right_0, s_left_1, s_right_1, s_left_2, s_right_2;
    logic        m_valid;
    logic        m_ready;
    logic [13:0] m_word_0, m_word_1, m_word_2, m_word_3;
    logic [13:0] m_word_4, m_word_5, m_word_6, m_word_7;
    logic [15:0] m_crc_word;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [0:0]  cfg_index;
    logic [0:0]  cfg_data;

    eiaj_pcm_line_block_encoder_top i_dut (.*);

    // Encoder model state.
    logic [15:0] hist_left  [RingSize][3];
    logic [15:0] hist_right [RingSize][3];
    int          next_slot;
    int          emph_lx, emph_ly, emph_rx, emph_ry;
    logic        mode16;
    logic        emph_en;

    line_words_t pending_lines [$];
    int          mismatches;
    int          lines_out;
    bit          no_idle;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic logic [13:0] hi14(input logic [15:0] u);
        return u[15:2];
    endfunction

    function automatic logic [13:0] lfsr_adv(input logic [13:0] u);
        logic [13:0] v;
        v = {u[12:0], 1'b0};
        if (u[13]) v = v ^ 14'h0101;
        return v;
    endfunction

    function automatic logic [15:0] emphasize(input logic [15:0] xin,
                                              inout int x1, inout int y1);
        longint acc;
        longint y;
        acc = 64'sd38156 * longint'($signed(xin)) - 64'sd24051 * longint'(x1)
              + 64'sd2278 * longint'(y1);
        y = acc >>> 14;
        if (y > 32767) y = 32767;
        else if (y < -32768) y = -32768;
        x1 = int'($signed(xin));
        y1 = int'(y);
        return y[15:0];
    endfunction

    function automatic int slot_back(input int k, input int d);
        return (k + RingSize - d) % RingSize;
    endfunction

    function automatic line_words_t encode_line(input logic cmd,
                                                input logic [0:5][15:0] smp);
        line_words_t r;
        logic [15:0] lq [3], rq [3], lp [3], rp [3];
        logic [15:0] p16, s16;
        logic [13:0] q;
        logic [15:0] c;
        int k, pk, qk;
        if (cmd == CmdControl) begin
            r.w = '{SyncA, SyncB, SyncA, SyncB, 14'd0, 14'd0, 14'd0, 14'd0};
            r.w[7] = {12'd0, mode16, ~emph_en};
        end else begin
            k = next_slot;
            for (int i = 0; i < 3; i++) begin
                hist_left[k][i]  = smp[2*i];
                hist_right[k][i] = smp[2*i+1];
            end
            if (emph_en) begin
                for (int i = 0; i < 3; i++) begin
                    hist_left[k][i]  = emphasize(smp[2*i], emph_lx, emph_ly);
                    hist_right[k][i] = emphasize(smp[2*i+1], emph_rx, emph_ry);
                end
            end
            next_slot = (k + 1) % RingSize;
            pk = slot_back(k, 96);
            qk = slot_back(k, 112);
            lp = hist_left[pk];
            rp = hist_right[pk];
            lq = hist_left[qk];
            rq = hist_right[qk];
            r.w[0] = hi14(hist_left[k][0]);
            r.w[1] = hi14(hist_right[slot_back(k, 16)][0]);
            r.w[2] = hi14(hist_left[slot_back(k, 32)][1]);
            r.w[3] = hi14(hist_right[slot_back(k, 48)][1]);
            r.w[4] = hi14(hist_left[slot_back(k, 64)][2]);
            r.w[5] = hi14(hist_right[slot_back(k, 80)][2]);
            p16 = lp[0] ^ rp[0] ^ lp[1] ^ rp[1] ^ lp[2] ^ rp[2];
            s16 = lq[0] ^ rq[0] ^ lq[1] ^ rq[1] ^ lq[2] ^ rq[2];
            if (!mode16) begin
                // The xor of truncated words equals the truncated xor.
                r.w[6] = hi14(p16);
                q = lfsr_adv(hi14(lq[0]));
                q = lfsr_adv(q ^ hi14(rq[0]));
                q = lfsr_adv(q ^ hi14(lq[1]));
                q = lfsr_adv(q ^ hi14(rq[1]));
                q = lfsr_adv(q ^ hi14(lq[2]));
                r.w[7] = lfsr_adv(q ^ hi14(rq[2]));
            end else begin
                r.w[6] = hi14(p16);
                r.w[7] = {lq[0][1:0], rq[0][1:0], lq[1][1:0], rq[1][1:0],
                          lq[2][1:0], rq[2][1:0], s16[1:0]};
            end
        end
        c = 16'hFFFF;
        for (int i = 0; i < 8; i++) begin
            for (int b = 13; b >= 0; b--) begin
                if (c[15] ^ r.w[i][b]) c = {c[14:0], 1'b0} ^ 16'h1021;
                else c = {c[14:0], 1'b0};
            end
        end
        r.crc = c;
        return r;
    endfunction

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 3))
            0: begin
                case ($urandom_range(0, 3))
                    0: return 16'h7FFF;
                    1: return 16'h8000;
                    2: return 16'h0000;
                    default: return 16'hFFFF;
                endcase
            end
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_line(input logic cmd, input logic [0:5][15:0] smp,
                             input bit chk, input logic [0:7][13:0] w_exp);
        int gap;
        line_words_t exp_line;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_command <= cmd;
        s_left_0  <= smp[0];
        s_right_0 <= smp[1];
        s_left_1  <= smp[2];
        s_right_1 <= smp[3];
        s_left_2  <= smp[4];
        s_right_2 <= smp[5];
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        exp_line = encode_line(cmd, smp);
        // Typed-in words are checked against the model, then used as expected values.
        if (chk) begin
            for (int i = 0; i < 8; i++) begin
                if (w_exp[i] !== exp_line.w[i]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("table word %0d: table %h model %h",
                                 i, w_exp[i], exp_line.w[i]);
                end
                exp_line.w[i] = w_exp[i];
            end
        end
        pending_lines.push_back(exp_line);
    endtask

    task automatic drain_and_configure(input logic sixteen, input logic emph);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_lines.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        for (int j = 0; j < 2; j++) begin
            cfg_valid <= 1'b1;
            cfg_index <= (j == 0) ? eplb_pkg::CfgSixteen : eplb_pkg::CfgEmphasis;
            cfg_data  <= (j == 0) ? sixteen : emph;
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            cfg_valid <= 1'b0;
            if (j == 0) mode16 = sixteen;
            else emph_en = emph;
            @(posedge aclk);
        end
    endtask

    // Result side: random stalls plus one long hold-off to fill the block.
    initial begin
        line_words_t e;
        logic [13:0] got [8];
        int wait_n;
        bit bad;
        m_ready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            wait_n = no_idle ? 0 : $urandom_range(0, 11);
            if (lines_out == 150) wait_n = StallLen;
            if (wait_n > 0) begin
                m_ready <= 1'b0;
                repeat (wait_n) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            lines_out++;
            got = '{m_word_0, m_word_1, m_word_2, m_word_3,
                    m_word_4, m_word_5, m_word_6, m_word_7};
            if (pending_lines.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result transaction");
            end else begin
                e = pending_lines.pop_front();
                bad = (m_crc_word !== e.crc);
                for (int i = 0; i < 8; i++)
                    if (got[i] !== e.w[i]) bad = 1'b1;
                if (bad) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("line %0d mismatch", lines_out);
                        for (int i = 0; i < 8; i++)
                            $display("  word_%0d exp %h got %h", i, e.w[i], got[i]);
                        $display("  crc exp %h got %h", e.crc, m_crc_word);
                    end
                end
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= DogLimit) begin
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    initial begin
        line_row_t rows [13];
        logic [0:5][15:0] smp;
        logic [1:0] settings [5];
        mismatches = 0;
        lines_out  = 0;
        no_idle    = 1'b0;
        for (int s = 0; s < RingSize; s++) begin
            for (int i = 0; i < 3; i++) begin
                hist_left[s][i]  = '0;
                hist_right[s][i] = '0;
            end
        end
        next_slot = 0;
        emph_lx = 0; emph_ly = 0; emph_rx = 0; emph_ry = 0;
        mode16  = 1'b0;
        emph_en = 1'b0;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_command = CmdData;
        {s_left_0, s_right_0, s_left_1, s_right_1, s_left_2, s_right_2} = '0;
        cfg_valid = 1'b0;
        cfg_index = eplb_pkg::CfgSixteen;
        cfg_data  = 1'b0;

        rows[0]  = '{CmdControl, {6{16'h0000}}, 1'b1,
                     {SyncA, SyncB, SyncA, SyncB, 14'd0, 14'd0, 14'd0, 14'd1}};
        rows[1]  = '{CmdData, {6{16'h0000}}, 1'b1, {8{14'd0}}};
        rows[2]  = '{CmdData, {6{16'h7FFF}}, 1'b1,
                     {14'h1FFF, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0}};
        rows[3]  = '{CmdData, {6{16'h8000}}, 1'b1,
                     {14'h2000, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0}};
        rows[4]  = '{CmdData, {6{16'hFFFF}}, 1'b1,
                     {14'h3FFF, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0}};
        rows[5]  = '{CmdData, {16'h0001, 16'hFFFE, 16'h0002, 16'hFFFD, 16'h0003, 16'h8001},
                     1'b0, '0};
        rows[6]  = '{CmdData, {16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA},
                     1'b0, '0};
        rows[7]  = '{CmdControl, {6{16'hFFFF}}, 1'b1,
                     {SyncA, SyncB, SyncA, SyncB, 14'd0, 14'd0, 14'd0, 14'd1}};
        rows[8]  = '{CmdData, {16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF},
                     1'b0, '0};
        rows[9]  = '{CmdData, {16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 16'h0F0F, 16'hF0F0},
                     1'b0, '0};
        rows[10] = '{CmdData, {16'h0003, 16'h0003, 16'h0003, 16'h0003, 16'h0003, 16'h0003},
                     1'b0, '0};
        rows[11] = '{CmdControl, {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000},
                     1'b1, {SyncA, SyncB, SyncA, SyncB, 14'd0, 14'd0, 14'd0, 14'd1}};
        rows[12] = '{CmdData, {6{16'h8000}}, 1'b0, '0};

        settings = '{2'b01, 2'b10, 2'b11, 2'b00, 2'b11};

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < 13; r++)
            send_line(rows[r].cmd, rows[r].smp, rows[r].chk, rows[r].w);

        for (int p = 0; p < 5; p++) begin
            drain_and_configure(settings[p][1], settings[p][0]);
            // One phase runs with no idling on either side.
            no_idle = (p == 3);
            // Emphasis extremes right after the setting changes.
            send_line(CmdData, {6{16'h7FFF}}, 1'b0, '0);
            send_line(CmdData, {6{16'h8000}}, 1'b0, '0);
            send_line(CmdControl, {6{16'h0000}}, 1'b0, '0);
            for (int n = 0; n < RandItems; n++) begin
                for (int i = 0; i < 6; i++) smp[i] = rand_sample();
                send_line(($urandom_range(0, 9) == 0) ? CmdControl : CmdData,
                          smp, 1'b0, '0);
            end
        end
        s_valid <= 1'b0;
        no_idle = 1'b0;
        while (pending_lines.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (mismatches == 0 && pending_lines.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+hdl
hdl/eplb_pkg.sv
hdl/eplb_ctrl.sv
hdl/eplb_datapath.sv
hdl/eiaj_pcm_line_block_encoder_top.sv
hdl/eplb_checker.sv
sim/tb.sv
